// ===== sv/blx_pkg.sv =====
// ----------------------------------------------------------------------------
// blx_pkg: shared types and constants of the byte stream lexer
// Token record, queue entry, queue status and token kind codes.
// ----------------------------------------------------------------------------
package blx_pkg;

  // token kinds, numbered in scanner order
  localparam logic [4:0] KIND_LPAREN     = 5'd0;
  localparam logic [4:0] KIND_RPAREN     = 5'd1;
  localparam logic [4:0] KIND_LBRACE     = 5'd2;
  localparam logic [4:0] KIND_RBRACE     = 5'd3;
  localparam logic [4:0] KIND_COMMA      = 5'd4;
  localparam logic [4:0] KIND_DOT        = 5'd5;
  localparam logic [4:0] KIND_MINUS_MINUS = 5'd6;
  localparam logic [4:0] KIND_MINUS_EQ   = 5'd7;
  localparam logic [4:0] KIND_MINUS      = 5'd8;
  localparam logic [4:0] KIND_PLUS_PLUS  = 5'd9;
  localparam logic [4:0] KIND_PLUS_EQ    = 5'd10;
  localparam logic [4:0] KIND_PLUS       = 5'd11;
  localparam logic [4:0] KIND_SEMI       = 5'd12;
  localparam logic [4:0] KIND_STAR_EQ    = 5'd13;
  localparam logic [4:0] KIND_STAR       = 5'd14;
  localparam logic [4:0] KIND_BANG_EQ    = 5'd15;
  localparam logic [4:0] KIND_BANG       = 5'd16;
  localparam logic [4:0] KIND_EQ_EQ      = 5'd17;
  localparam logic [4:0] KIND_EQ         = 5'd18;
  localparam logic [4:0] KIND_LT_EQ      = 5'd19;
  localparam logic [4:0] KIND_LT         = 5'd20;
  localparam logic [4:0] KIND_GT_EQ      = 5'd21;
  localparam logic [4:0] KIND_GT         = 5'd22;
  localparam logic [4:0] KIND_STRING     = 5'd23;
  localparam logic [4:0] KIND_PCT_EQ     = 5'd24;
  localparam logic [4:0] KIND_PCT        = 5'd25;
  localparam logic [4:0] KIND_SLASH_EQ   = 5'd26;
  localparam logic [4:0] KIND_SLASH      = 5'd27;
  localparam logic [4:0] KIND_NUMBER     = 5'd28;
  localparam logic [4:0] KIND_IDENT      = 5'd29;
  localparam logic [4:0] KIND_ERROR      = 5'd30;

  // literal kinds
  localparam logic [1:0] LK_NONE   = 2'd0;
  localparam logic [1:0] LK_STRING = 2'd1;
  localparam logic [1:0] LK_INT    = 2'd2;
  localparam logic [1:0] LK_FLOAT  = 2'd3;

  localparam int unsigned QDEPTH = 4;

  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  lit;
    logic [15:0] line;
    logic [15:0] start;
    logic [15:0] len;
    logic        unterm;
  } token_t;

  // tokens caused by one byte: tok0 always, tok1 when two is set
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } step_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/byte_stream_lexer.sv =====
// ----------------------------------------------------------------------------
// byte_stream_lexer: streaming lexical scanner
// Scans source bytes into tokens with kind, literal kind, line, start
// offset and length; scanner, token queue and output stage run decoupled.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata bits  tuser bits  tlast
// s_axis    in   8           -           end of text (last byte)
// m_axis    out  48          8           last token caused by one byte
//
// One byte is taken per cycle while the token queue has room. Each token
// leaves the output register in its own transfer, so a byte that closes two
// tokens sends them one after the other, through the queue and the output
// register. The queue of four records absorbs output stalls.
// Reset clears scanner state, queue pointers and the output valid flag.
// ----------------------------------------------------------------------------
module byte_stream_lexer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_byte
  input  logic        s_axis_tlast,  // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] line_number, [31:16] start_offset, [47:32] token_length
  output logic [47:0] m_axis_tdata,
  // [4:0] token_kind, [6:5] literal_kind, [7] unterminated
  output logic [7:0]  m_axis_tuser,
  output logic        m_axis_tlast   // last_of_run
);

  logic               push, pop;
  blx_pkg::step_t     push_data, head;
  blx_pkg::q_status_t q_status;
  blx_pkg::token_t    out_tok;

  blx_scan #(
    .PosBits (POSITION_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eot_i    (s_axis_tlast),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  blx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  blx_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tok_o   (out_tok),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_tok.len, out_tok.start, out_tok.line};
  assign m_axis_tuser = {out_tok.unterm, out_tok.lit, out_tok.kind};

`ifndef SYNTHESIS
  // scanner never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("token pushed into full queue");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[47:32] != 16'd0))
    else $error("token with zero length");

  a_unterm_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[7]) |->
      (m_axis_tuser[4:0] == blx_pkg::KIND_STRING &&
       m_axis_tuser[6:5] == blx_pkg::LK_STRING))
    else $error("unterminated flag on non-string token");
`endif

endmodule

// ===== sv/blx_scan.sv =====
// ----------------------------------------------------------------------------
// blx_scan: front end of the lexer
// Takes one byte per transfer, advances the scanner state and pushes the
// zero, one or two tokens that the byte closes into the token queue.
// ----------------------------------------------------------------------------
module blx_scan #(
  parameter int unsigned PosBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_eot_i,
  input  blx_pkg::q_status_t q_status_i,
  output logic               push_o,
  output blx_pkg::step_t     push_data_o
);

  localparam int unsigned LW = (PosBits + 1 > 17) ? PosBits + 1 : 17;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [3:0] {
    M_IDLE, M_STRING, M_INT, M_FLOAT, M_IDENT, M_COMMENT,
    M_OP_MINUS, M_OP_PLUS, M_OP_STAR, M_OP_BANG, M_OP_EQ,
    M_OP_LT, M_OP_GT, M_OP_PCT, M_OP_SLASH
  } mode_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_op_mode(input mode_e m);
    return (m == M_OP_MINUS) || (m == M_OP_PLUS) || (m == M_OP_STAR) ||
           (m == M_OP_BANG) || (m == M_OP_EQ) || (m == M_OP_LT) ||
           (m == M_OP_GT) || (m == M_OP_PCT) || (m == M_OP_SLASH);
  endfunction

  function automatic logic [4:0] op_alone(input mode_e m);
    unique case (m)
      M_OP_MINUS: return blx_pkg::KIND_MINUS;
      M_OP_PLUS:  return blx_pkg::KIND_PLUS;
      M_OP_STAR:  return blx_pkg::KIND_STAR;
      M_OP_BANG:  return blx_pkg::KIND_BANG;
      M_OP_EQ:    return blx_pkg::KIND_EQ;
      M_OP_LT:    return blx_pkg::KIND_LT;
      M_OP_GT:    return blx_pkg::KIND_GT;
      M_OP_PCT:   return blx_pkg::KIND_PCT;
      M_OP_SLASH: return blx_pkg::KIND_SLASH;
      default:    return blx_pkg::KIND_ERROR;
    endcase
  endfunction

  function automatic logic [4:0] op_with_eq(input mode_e m);
    unique case (m)
      M_OP_MINUS: return blx_pkg::KIND_MINUS_EQ;
      M_OP_PLUS:  return blx_pkg::KIND_PLUS_EQ;
      M_OP_STAR:  return blx_pkg::KIND_STAR_EQ;
      M_OP_BANG:  return blx_pkg::KIND_BANG_EQ;
      M_OP_EQ:    return blx_pkg::KIND_EQ_EQ;
      M_OP_LT:    return blx_pkg::KIND_LT_EQ;
      M_OP_GT:    return blx_pkg::KIND_GT_EQ;
      M_OP_PCT:   return blx_pkg::KIND_PCT_EQ;
      M_OP_SLASH: return blx_pkg::KIND_SLASH_EQ;
      default:    return blx_pkg::KIND_ERROR;
    endcase
  endfunction

  // saturate to 16 bits
  function automatic logic [15:0] sat16(input logic [PosBits:0] v);
    logic [LW-1:0] w;
    w = LW'(v);
    if (w > LW'(17'h0FFFF)) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

  // saturate, then never below one
  function automatic logic [15:0] len16(input logic [PosBits:0] v);
    logic [15:0] s;
    s = sat16(v);
    if (s == 16'd0) begin
      return 16'd1;
    end
    return s;
  endfunction

  mode_e              mode_q, mode_d, mode_a;
  logic [15:0]        line_q, line_d, line_a;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] ts_q, ts_d, ts_a;

  logic               accept;
  logic               used, ts_set;
  logic [PosBits:0]   len_exact, len_inc;
  logic [15:0]        pos_sat;
  logic               e1_v, e2_v;
  blx_pkg::token_t    e1, e2;
  blx_pkg::step_t     step;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign len_exact = {1'b0, pos_q - ts_q};
  assign len_inc   = len_exact + {{PosBits{1'b0}}, 1'b1};
  assign pos_sat   = sat16({1'b0, pos_q});

  always_comb begin
    used   = 1'b0;
    ts_set = 1'b0;
    mode_a = M_IDLE;
    ts_a   = ts_q;
    line_a = line_q;
    e1_v   = 1'b0;
    e1     = '{kind: blx_pkg::KIND_ERROR, lit: blx_pkg::LK_NONE, line: line_q,
               start: sat16({1'b0, ts_q}), len: 16'd1, unterm: 1'b0};
    e2_v   = 1'b0;
    e2     = '{kind: blx_pkg::KIND_ERROR, lit: blx_pkg::LK_NONE, line: line_q,
               start: pos_sat, len: 16'd1, unterm: 1'b0};

    // pending token: continue or close it
    unique case (mode_q)
      M_STRING: begin
        used = 1'b1;
        if (in_byte_i == CH_QUOTE) begin
          e1_v     = 1'b1;
          e1.kind  = blx_pkg::KIND_STRING;
          e1.lit   = blx_pkg::LK_STRING;
          e1.len   = len16(len_inc);
        end else begin
          mode_a = M_STRING;
        end
      end
      M_COMMENT: begin
        if (in_byte_i != CH_NL) begin
          used   = 1'b1;
          mode_a = M_COMMENT;
        end
      end
      M_INT, M_FLOAT: begin
        if (is_digit(in_byte_i)) begin
          used   = 1'b1;
          mode_a = mode_q;
        end else if (mode_q == M_INT && in_byte_i == CH_DOT) begin
          used   = 1'b1;
          mode_a = M_FLOAT;
        end else begin
          e1_v    = 1'b1;
          e1.kind = blx_pkg::KIND_NUMBER;
          e1.lit  = (mode_q == M_INT) ? blx_pkg::LK_INT : blx_pkg::LK_FLOAT;
          e1.len  = len16(len_exact);
        end
      end
      M_IDENT: begin
        if (is_alpha(in_byte_i) || is_digit(in_byte_i)) begin
          used   = 1'b1;
          mode_a = M_IDENT;
        end else begin
          e1_v    = 1'b1;
          e1.kind = blx_pkg::KIND_IDENT;
          e1.len  = len16(len_exact);
        end
      end
      M_OP_MINUS, M_OP_PLUS, M_OP_STAR, M_OP_BANG, M_OP_EQ,
      M_OP_LT, M_OP_GT, M_OP_PCT, M_OP_SLASH: begin
        if (in_byte_i == CH_EQ) begin
          used    = 1'b1;
          e1_v    = 1'b1;
          e1.kind = op_with_eq(mode_q);
          e1.len  = len16(len_inc);
        end else if (mode_q == M_OP_SLASH && in_byte_i == CH_SLASH) begin
          used   = 1'b1;
          mode_a = M_COMMENT;
        end else if ((mode_q == M_OP_MINUS && in_byte_i == CH_MINUS) ||
                     (mode_q == M_OP_PLUS && in_byte_i == CH_PLUS)) begin
          used    = 1'b1;
          e1_v    = 1'b1;
          e1.kind = (mode_q == M_OP_MINUS) ? blx_pkg::KIND_MINUS_MINUS
                                           : blx_pkg::KIND_PLUS_PLUS;
          e1.len  = len16(len_inc);
        end else begin
          e1_v    = 1'b1;
          e1.kind = op_alone(mode_q);
          e1.len  = 16'd1;
        end
      end
      default: begin
        mode_a = M_IDLE;
      end
    endcase

    // byte not consumed above: scan it as a fresh token
    if (!used) begin
      unique case (in_byte_i)
        CH_MINUS:  begin mode_a = M_OP_MINUS; ts_set = 1'b1; end
        CH_PLUS:   begin mode_a = M_OP_PLUS;  ts_set = 1'b1; end
        CH_STAR:   begin mode_a = M_OP_STAR;  ts_set = 1'b1; end
        CH_BANG:   begin mode_a = M_OP_BANG;  ts_set = 1'b1; end
        CH_EQ:     begin mode_a = M_OP_EQ;    ts_set = 1'b1; end
        CH_LT:     begin mode_a = M_OP_LT;    ts_set = 1'b1; end
        CH_GT:     begin mode_a = M_OP_GT;    ts_set = 1'b1; end
        CH_PCT:    begin mode_a = M_OP_PCT;   ts_set = 1'b1; end
        CH_SLASH:  begin mode_a = M_OP_SLASH; ts_set = 1'b1; end
        CH_LPAREN: begin e2_v = 1'b1; e2.kind = blx_pkg::KIND_LPAREN; end
        CH_RPAREN: begin e2_v = 1'b1; e2.kind = blx_pkg::KIND_RPAREN; end
        CH_LBRACE: begin e2_v = 1'b1; e2.kind = blx_pkg::KIND_LBRACE; end
        CH_RBRACE: begin e2_v = 1'b1; e2.kind = blx_pkg::KIND_RBRACE; end
        CH_COMMA:  begin e2_v = 1'b1; e2.kind = blx_pkg::KIND_COMMA; end
        CH_DOT:    begin e2_v = 1'b1; e2.kind = blx_pkg::KIND_DOT; end
        CH_SEMI:   begin e2_v = 1'b1; e2.kind = blx_pkg::KIND_SEMI; end
        CH_QUOTE:  begin mode_a = M_STRING; ts_set = 1'b1; end
        CH_NL: begin
          if (line_q != 16'hFFFF) begin
            line_a = line_q + 16'd1;
          end
        end
        CH_SPACE, CH_CR, CH_TAB: begin
          mode_a = M_IDLE;
        end
        default: begin
          if (is_digit(in_byte_i)) begin
            mode_a = M_INT;
            ts_set = 1'b1;
          end else if (is_alpha(in_byte_i)) begin
            mode_a = M_IDENT;
            ts_set = 1'b1;
          end else begin
            e2_v = 1'b1;
          end
        end
      endcase
      if (ts_set) begin
        ts_a = pos_q;
      end
    end

    // end of text flushes whatever is still pending
    if (in_eot_i && mode_a != M_IDLE && mode_a != M_COMMENT) begin
      e2_v     = 1'b1;
      e2.start = sat16({1'b0, ts_a});
      e2.len   = ts_set ? 16'd1 : len16(len_inc);
      if (mode_a == M_STRING) begin
        e2.kind   = blx_pkg::KIND_STRING;
        e2.lit    = blx_pkg::LK_STRING;
        e2.unterm = 1'b1;
      end else if (mode_a == M_INT) begin
        e2.kind = blx_pkg::KIND_NUMBER;
        e2.lit  = blx_pkg::LK_INT;
      end else if (mode_a == M_FLOAT) begin
        e2.kind = blx_pkg::KIND_NUMBER;
        e2.lit  = blx_pkg::LK_FLOAT;
      end else if (mode_a == M_IDENT) begin
        e2.kind = blx_pkg::KIND_IDENT;
      end else if (is_op_mode(mode_a)) begin
        e2.kind = op_alone(mode_a);
        e2.len  = 16'd1;
      end
    end

    if (e1_v) begin
      step = '{two: e2_v, tok0: e1, tok1: e2};
    end else begin
      step = '{two: 1'b0, tok0: e2, tok1: e2};
    end

    if (in_eot_i) begin
      mode_d = M_IDLE;
      line_d = '0;
      pos_d  = '0;
      ts_d   = '0;
    end else begin
      mode_d = mode_a;
      line_d = line_a;
      ts_d   = ts_a;
      pos_d  = (pos_q == {PosBits{1'b1}}) ? pos_q : pos_q + 1'b1;
    end
  end

  assign push_o      = accept && (e1_v || e2_v);
  assign push_data_o = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      line_q <= '0;
      pos_q  <= '0;
      ts_q   <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      line_q <= line_d;
      pos_q  <= pos_d;
      ts_q   <= ts_d;
    end
  end

endmodule

// ===== sv/blx_queue.sv =====
// ----------------------------------------------------------------------------
// blx_queue: token queue between scanner and output stage
// Small register FIFO of per-byte token records, head visible at once.
// ----------------------------------------------------------------------------
module blx_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  blx_pkg::step_t     push_data_i,
  input  logic               pop_i,
  output blx_pkg::step_t     head_o,
  output blx_pkg::q_status_t status_o
);

  localparam int unsigned PW = (blx_pkg::QDEPTH > 1) ? $clog2(blx_pkg::QDEPTH) : 1;
  localparam int unsigned CW = $clog2(blx_pkg::QDEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(blx_pkg::QDEPTH - 1);

  blx_pkg::step_t  mem_q [blx_pkg::QDEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CW'(blx_pkg::QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/blx_emit.sv =====
// ----------------------------------------------------------------------------
// blx_emit: output stage of the lexer
// Pops token records and sends their one or two tokens out through a
// registered stream stage, marking the last token of each byte.
// ----------------------------------------------------------------------------
module blx_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blx_pkg::step_t     head_i,
  input  blx_pkg::q_status_t status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output blx_pkg::token_t    out_tok_o,
  output logic               out_last_o
);

  logic            valid_q, valid_d;
  logic            sel_q, sel_d;
  blx_pkg::token_t tok_q;
  logic            last_q;
  logic            adv, take, is_last;
  blx_pkg::token_t cur;

  assign adv     = !valid_q || out_ready_i;
  assign take    = adv && !status_i.empty;
  assign cur     = sel_q ? head_i.tok1 : head_i.tok0;
  assign is_last = sel_q || !head_i.two;
  assign pop_o   = take && is_last;

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (adv) begin
      valid_d = take;
      if (take) begin
        sel_d = !is_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_q  <= cur;
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;
  assign out_last_o  = last_q;

endmodule
